// File: rtl/core/nsp_pkg.sv
// ----------------------------------------------------------------------------
// nsp_pkg: shared types and constants of the nested section profiler
// Holds the transaction payload structs, the action and status codes, the
// controller states and the command and status bundles between the modules.
// ----------------------------------------------------------------------------
package nsp_pkg;

  localparam int unsigned STACK_DEPTH_DEF   = 16;
  localparam int unsigned SECTION_COUNT_DEF = 64;
  localparam int unsigned TICK_BITS_DEF     = 32;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned TS_W     = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned LEVEL_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENTER = 2'd0,
    ACT_EXIT  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EXIT_EL,
    S_EXIT_UPD,
    S_QUERY,
    S_DIV,
    S_RESPOND
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     section_id;
    logic [TS_W-1:0]     timestamp;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TS_W-1:0]     elapsed_ticks;
    logic [COUNT_W-1:0]  hit_count;
    logic [TOTAL_W-1:0]  total_ticks;
    logic [TS_W-1:0]     min_ticks;
    logic [TS_W-1:0]     max_ticks;
    logic [TOTAL_W-1:0]  average_ticks;
    logic [LEVEL_W-1:0]  stack_level;
  } out_item_t;

  typedef struct packed {
    logic    capture;
    logic    clear_step;
    logic    push;
    logic    pop;
    logic    calc_el;
    logic    update;
    logic    load_stats;
    logic    set_status;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    action_e action;
    logic    stack_empty;
    logic    stack_full;
    logic    clear_last;
    logic    div_busy;
  } ctrl_sts_t;

endpackage

// File: rtl/core/nested_section_profiler.sv
// ----------------------------------------------------------------------------
// nested_section_profiler: nested section profiler with min, max and average
// Tracks open sections on a timestamp stack and keeps per-section hit count,
// total, minimum and maximum elapsed ticks; exit and query return the average.
//
//   Channel   Ports                     Transaction
//   command   start, busy, item_i       accepted when start is high, busy low
//   result    done_o, result_o          valid for the one cycle done_o is high
//
// An enter, a failed exit or a bad action goes from S_DECODE to S_RESPOND,
// which raises the result strobe. After S_DECODE an exit passes S_EXIT_EL,
// S_EXIT_UPD and S_DIV, a query S_QUERY and S_DIV; S_DIV waits for the serial
// divider that forms the average, one quotient bit per cycle over 48 bits.
// busy is high from S_DECODE to the strobe; a new transaction can be accepted
// in the next cycle. After reset the statistics memory is cleared, one section
// per cycle, while busy is high. The receiver cannot stall a result.
// ----------------------------------------------------------------------------
module nested_section_profiler
  import nsp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int unsigned SECTION_COUNT = SECTION_COUNT_DEF,
  parameter int unsigned TICK_BITS     = TICK_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      done_o,
  output out_item_t result_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  nsp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  nsp_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .SECTION_COUNT (SECTION_COUNT),
    .TICK_BITS     (TICK_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule

// File: rtl/core/nsp_div.sv
// ----------------------------------------------------------------------------
// nsp_div: serial restoring divider
// Divides the section total by the hit count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nsp_div
  import nsp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TOTAL_W-1:0] dividend_i,
  input  logic [COUNT_W-1:0] divisor_i,
  output logic               busy_o,
  output logic [TOTAL_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(TOTAL_W);

  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TOTAL_W-1:0] quo_q, quo_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [COUNT_W-1:0] dsr_q, dsr_d;
  logic [COUNT_W:0]   rem_sh;
  logic               ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[TOTAL_W-1]};
    ge     = (rem_sh >= {1'b0, dsr_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(TOTAL_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[TOTAL_W-2:0], ge};
      rem_d = ge ? COUNT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[COUNT_W-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/core/nsp_datapath.sv
// ----------------------------------------------------------------------------
// nsp_datapath: stack, statistics table and result registers
// Holds the start-time stack, the per-section statistics memory, the stack
// pointer, the clearing counter and the average divider.
// ----------------------------------------------------------------------------
module nsp_datapath
  import nsp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int unsigned SECTION_COUNT = SECTION_COUNT_DEF,
  parameter int unsigned TICK_BITS     = TICK_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  ctrl_cmd_t cmd_i,
  output ctrl_sts_t sts_o,
  output out_item_t result_o
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SIW = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
  localparam int unsigned RW  = 18;

  typedef logic [TICK_BITS-1:0] tick_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    tick_t              min;
    tick_t              max;
  } entry_t;

  tick_t    stack_mem [STACK_DEPTH];
  entry_t   tbl_mem   [SECTION_COUNT];

  logic [ACTION_W-1:0] act_q;
  logic [SIW-1:0]      idx_q, idx_d;
  tick_t               ts_q;
  logic [SPW-1:0]      sp_q, sp_d, sp_m1;
  logic [SIW-1:0]      clr_q;
  tick_t               el_q;
  tick_t               stk_rd_q;
  entry_t              tbl_rd_q;
  status_e             res_status_q;
  tick_t               res_el_q;
  entry_t              res_entry_q;

  logic [RW-1:0]       red;
  entry_t              new_entry;
  logic [TOTAL_W:0]    sum;
  logic                cnt_zero;
  logic                tbl_we;
  logic [SIW-1:0]      tbl_waddr;
  entry_t              tbl_wdata;
  logic                div_start;
  logic [TOTAL_W-1:0]  div_dividend;
  logic [COUNT_W-1:0]  div_divisor;
  logic                div_busy;
  logic [TOTAL_W-1:0]  quotient;

  always_comb begin
    red = RW'(item_i.section_id);
    for (int s = ID_W - 1; s >= 0; s--) begin
      if (red >= (RW'(SECTION_COUNT) << s)) begin
        red = red - (RW'(SECTION_COUNT) << s);
      end
    end
    idx_d = red[SIW-1:0];
  end

  assign sp_m1 = sp_q - 1'b1;

  always_comb begin
    sp_d = sp_q;
    if (cmd_i.push) begin
      sp_d = sp_q + 1'b1;
    end else if (cmd_i.pop) begin
      sp_d = sp_m1;
    end
  end

  always_comb begin
    cnt_zero        = (tbl_rd_q.count == '0);
    sum             = {1'b0, tbl_rd_q.total} + (TOTAL_W + 1)'(el_q);
    new_entry.count = (tbl_rd_q.count != '1) ? tbl_rd_q.count + 1'b1 : tbl_rd_q.count;
    new_entry.total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    new_entry.min   = (cnt_zero || (el_q < tbl_rd_q.min)) ? el_q : tbl_rd_q.min;
    new_entry.max   = (cnt_zero || (el_q > tbl_rd_q.max)) ? el_q : tbl_rd_q.max;
  end

  always_comb begin
    tbl_we    = cmd_i.clear_step || cmd_i.update;
    tbl_waddr = cmd_i.clear_step ? clr_q : idx_q;
    tbl_wdata = cmd_i.clear_step ? '0 : new_entry;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd_q <= tbl_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_mem[sp_q[SAW-1:0]] <= ts_q;
    end
    stk_rd_q <= stack_mem[sp_m1[SAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= '0;
      clr_q <= '0;
    end else begin
      sp_q <= sp_d;
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q        <= item_i.action;
      idx_q        <= idx_d;
      ts_q         <= tick_t'(item_i.timestamp);
      res_status_q <= ST_OK;
      res_el_q     <= '0;
      res_entry_q  <= '0;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
    end
    if (cmd_i.calc_el) begin
      el_q <= ts_q - stk_rd_q;
    end
    if (cmd_i.update) begin
      res_el_q    <= el_q;
      res_entry_q <= new_entry;
    end
    if (cmd_i.load_stats) begin
      res_entry_q <= tbl_rd_q;
    end
  end

  always_comb begin
    div_start    = cmd_i.update || cmd_i.load_stats;
    div_dividend = cmd_i.update ? new_entry.total : tbl_rd_q.total;
    div_divisor  = cmd_i.update ? new_entry.count : tbl_rd_q.count;
  end

  nsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_comb begin
    sts_o.action      = action_e'(act_q);
    sts_o.stack_empty = (sp_q == '0);
    sts_o.stack_full  = (sp_q >= SPW'(STACK_DEPTH));
    sts_o.clear_last  = (clr_q == SIW'(SECTION_COUNT - 1));
    sts_o.div_busy    = div_busy;
  end

  always_comb begin
    result_o.status        = res_status_q;
    result_o.elapsed_ticks = TS_W'(res_el_q);
    result_o.hit_count     = res_entry_q.count;
    result_o.total_ticks   = res_entry_q.total;
    result_o.min_ticks     = TS_W'(res_entry_q.min);
    result_o.max_ticks     = TS_W'(res_entry_q.max);
    result_o.average_ticks = (res_entry_q.count != '0) ? quotient : '0;
    result_o.stack_level   = LEVEL_W'(sp_q);
  end

endmodule

// File: rtl/core/nsp_ctrl.sv
// ----------------------------------------------------------------------------
// nsp_ctrl: profiler controller
// Sequences the clearing pass, decodes each transaction and steps the
// datapath through stack access, statistics update and division.
// ----------------------------------------------------------------------------
module nsp_ctrl
  import nsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.action)
          ACT_ENTER: begin
            if (sts_i.stack_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.push = 1'b1;
            end
            state_d = S_RESPOND;
          end
          ACT_EXIT: begin
            if (sts_i.stack_empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY;
              state_d          = S_RESPOND;
            end else begin
              cmd_o.pop = 1'b1;
              state_d   = S_EXIT_EL;
            end
          end
          ACT_QUERY: begin
            state_d = S_QUERY;
          end
          default: begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_BAD;
            state_d          = S_RESPOND;
          end
        endcase
      end
      S_EXIT_EL: begin
        cmd_o.calc_el = 1'b1;
        state_d       = S_EXIT_UPD;
      end
      S_EXIT_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_DIV;
      end
      S_QUERY: begin
        cmd_o.load_stats = 1'b1;
        state_d          = S_DIV;
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = S_RESPOND;
        end
      end
      S_RESPOND: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
